/* src/tpe_pkg.sv */
// ----------------------------------------------------------------------------
// Trivariate polynomial evaluator package
// Shared widths, fixed-point constants, register indexes and types.
// ----------------------------------------------------------------------------
package tpe_pkg;

    // Field widths
    localparam int IN_W      = 16;   // Q8.8 argument
    localparam int Q_W       = 48;   // Q32.16 products, powers and result
    localparam int DEG_W     = 3;    // one degree field
    localparam int COEF_W    = 32;   // Q16.16 coefficient
    localparam int WORD_W    = 41;   // one term word
    localparam int CNT_W     = 3;    // term count register
    localparam int CFG_IDX_W = 3;    // configuration register index

    // Term word layout
    localparam int COEF_LSB  = 9;

    // Default sizes handed to the top level
    localparam int DEF_MAX_TERMS  = 7;
    localparam int DEF_MAX_DEGREE = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_WORD_0 = 3'd1;

    // Fixed-point constants
    localparam logic [Q_W-1:0] ONE_Q16 = 48'd65536;
    localparam logic [Q_W-1:0] Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic signed [Q_W-1:0] q_t;

endpackage

/* src/tpe_mul_sat.sv */
// ----------------------------------------------------------------------------
// Saturating fixed-point multiplier
// Two-stage signed multiply split into two partial products, followed by a
// flooring right shift and a clamp to 48 bits. A side word travels along.
// ----------------------------------------------------------------------------
module tpe_mul_sat #(
    parameter int A_W    = 48,
    parameter int B_W    = 48,
    parameter int SHIFT  = 16,
    parameter int SIDE_W = 1
) (
    input  logic                   aclk,
    input  logic                   ce,
    input  logic signed [A_W-1:0]  a,
    input  logic signed [B_W-1:0]  b,
    input  logic                   sat_in,
    input  logic [SIDE_W-1:0]      side_in,
    output tpe_pkg::q_t            q,
    output logic                   sat,
    output logic [SIDE_W-1:0]      side_out
);
    import tpe_pkg::*;

    localparam int LO_W = B_W / 2;
    localparam int HI_W = B_W - LO_W;
    localparam int P_W  = A_W + B_W;
    localparam int SH_W = P_W - SHIFT;

    logic signed [A_W+LO_W:0]   plo_reg;
    logic signed [A_W+HI_W-1:0] phi_reg;
    logic                       sat_s1_reg;
    logic [SIDE_W-1:0]          side_s1_reg;

    logic signed [P_W-1:0]      full;
    logic signed [SH_W-1:0]     shifted;
    logic [SH_W-Q_W:0]          top_bits;
    logic                       ovf;
    logic [Q_W-1:0]             q_next;

    logic [Q_W-1:0]             q_reg;
    logic                       sat_reg;
    logic [SIDE_W-1:0]          side_reg;

    // Partial products: unsigned low half and signed high half of b.
    always_ff @(posedge aclk) begin
        if (ce) begin
            plo_reg     <= a * $signed({1'b0, b[LO_W-1:0]});
            phi_reg     <= a * $signed(b[B_W-1:LO_W]);
            sat_s1_reg  <= sat_in;
            side_s1_reg <= side_in;
        end
    end

    // Recombine, floor shift and clamp to the 48-bit range.
    always_comb begin
        full     = (P_W'(phi_reg) <<< LO_W) + P_W'(plo_reg);
        shifted  = SH_W'(full >>> SHIFT);
        top_bits = shifted[SH_W-1:Q_W-1];
        ovf      = !((&top_bits) || !(|top_bits));
        if (ovf) begin
            q_next = shifted[SH_W-1] ? Q_MIN : Q_MAX;
        end else begin
            q_next = shifted[Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            q_reg    <= q_next;
            sat_reg  <= sat_s1_reg | ovf;
            side_reg <= side_s1_reg;
        end
    end

    assign q        = q_reg;
    assign sat      = sat_reg;
    assign side_out = side_reg;

endmodule

/* src/tpe_power_chain.sv */
// ----------------------------------------------------------------------------
// Power chain
// Builds the powers 0..MAX_DEGREE of one Q8.8 argument in Q32.16, one
// multiplier per power above x^0. A saturated power marks all higher powers.
// ----------------------------------------------------------------------------
module tpe_power_chain #(
    parameter int MAX_DEGREE = tpe_pkg::DEF_MAX_DEGREE
) (
    input  logic                                   aclk,
    input  logic                                   ce,
    input  logic signed [tpe_pkg::IN_W-1:0]        arg,
    output logic [MAX_DEGREE:0][tpe_pkg::Q_W-1:0]  pw,
    output logic [MAX_DEGREE:0]                    ps
);
    import tpe_pkg::*;

    localparam int ARR_W = (MAX_DEGREE + 1) * Q_W + (MAX_DEGREE + 1);

    logic [MAX_DEGREE:0][MAX_DEGREE:0][Q_W-1:0] pw_st;
    logic [MAX_DEGREE:0][MAX_DEGREE:0]          ps_st;
    logic [IN_W-1:0]                            arg_st [0:MAX_DEGREE-1];

    // Stage zero: x^0 is one, nothing saturated yet.
    always_comb begin
        pw_st[0]    = '0;
        pw_st[0][0] = ONE_Q16;
        ps_st[0]    = '0;
    end
    assign arg_st[0] = arg;

    genvar k;
    generate
        for (k = 1; k <= MAX_DEGREE; k++) begin : g_stage
            logic [Q_W-1:0]        q;
            logic                  sat;
            logic [MAX_DEGREE:0][Q_W-1:0] pw_d;
            logic [MAX_DEGREE:0]   ps_d;

            if (k < MAX_DEGREE) begin : g_mid
                logic [ARR_W+IN_W-1:0] side_o;
                tpe_mul_sat #(
                    .A_W(Q_W), .B_W(IN_W), .SHIFT(8), .SIDE_W(ARR_W + IN_W)
                ) u_mul (
                    .aclk(aclk), .ce(ce),
                    .a(pw_st[k-1][k-1]), .b(arg_st[k-1]),
                    .sat_in(ps_st[k-1][k-1]),
                    .side_in({arg_st[k-1], pw_st[k-1], ps_st[k-1]}),
                    .q(q), .sat(sat), .side_out(side_o)
                );
                assign {arg_st[k], pw_d, ps_d} = side_o;
            end else begin : g_last
                logic [ARR_W-1:0] side_o;
                tpe_mul_sat #(
                    .A_W(Q_W), .B_W(IN_W), .SHIFT(8), .SIDE_W(ARR_W)
                ) u_mul (
                    .aclk(aclk), .ce(ce),
                    .a(pw_st[k-1][k-1]), .b(arg_st[k-1]),
                    .sat_in(ps_st[k-1][k-1]),
                    .side_in({pw_st[k-1], ps_st[k-1]}),
                    .q(q), .sat(sat), .side_out(side_o)
                );
                assign {pw_d, ps_d} = side_o;
            end

            // Insert the new power into the carried tables.
            always_comb begin
                pw_st[k]    = pw_d;
                pw_st[k][k] = q;
                ps_st[k]    = ps_d;
                ps_st[k][k] = sat;
            end
        end
    endgenerate

    assign pw = pw_st[MAX_DEGREE];
    assign ps = ps_st[MAX_DEGREE];

endmodule

/* src/tpe_term_lane.sv */
// ----------------------------------------------------------------------------
// Term lane
// Evaluates one term coef * x^a * y^b * z^c as three chained saturating
// multiplies, six register stages in all.
// ----------------------------------------------------------------------------
module tpe_term_lane #(
    parameter int MAX_DEGREE = tpe_pkg::DEF_MAX_DEGREE
) (
    input  logic                                   aclk,
    input  logic                                   ce,
    input  logic [tpe_pkg::WORD_W-1:0]             term_word,
    input  logic                                   active,
    input  logic [MAX_DEGREE:0][tpe_pkg::Q_W-1:0]  pw_x,
    input  logic [MAX_DEGREE:0][tpe_pkg::Q_W-1:0]  pw_y,
    input  logic [MAX_DEGREE:0][tpe_pkg::Q_W-1:0]  pw_z,
    input  logic [MAX_DEGREE:0]                    ps_x,
    input  logic [MAX_DEGREE:0]                    ps_y,
    input  logic [MAX_DEGREE:0]                    ps_z,
    output tpe_pkg::q_t                            term,
    output logic                                   term_sat,
    output logic                                   term_active
);
    import tpe_pkg::*;

    logic [DEG_W-1:0] dx, dy, dz;
    logic [Q_W-1:0]   sel_x, sel_y, sel_z;
    logic             sat_x, sat_y, sat_z;

    logic [Q_W-1:0]   t0, t1;
    logic             s0, s1;
    logic [2*Q_W:0]   side0;
    logic [Q_W:0]     side1;

    function automatic logic [DEG_W-1:0] deg_clamp(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] r;
        r = (d > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : d;
        return r;
    endfunction

    // Pick each variable's power by the clamped degree.
    always_comb begin
        dx    = deg_clamp(term_word[DEG_W-1:0]);
        dy    = deg_clamp(term_word[2*DEG_W-1:DEG_W]);
        dz    = deg_clamp(term_word[3*DEG_W-1:2*DEG_W]);
        sel_x = '0;
        sel_y = '0;
        sel_z = '0;
        sat_x = 1'b0;
        sat_y = 1'b0;
        sat_z = 1'b0;
        for (int j = 0; j <= MAX_DEGREE; j++) begin
            if (dx == DEG_W'(j)) begin
                sel_x = pw_x[j];
                sat_x = ps_x[j];
            end
            if (dy == DEG_W'(j)) begin
                sel_y = pw_y[j];
                sat_y = ps_y[j];
            end
            if (dz == DEG_W'(j)) begin
                sel_z = pw_z[j];
                sat_z = ps_z[j];
            end
        end
    end

    // Coefficient times the x power.
    tpe_mul_sat #(
        .A_W(COEF_W), .B_W(Q_W), .SHIFT(16), .SIDE_W(2*Q_W + 1)
    ) u_mul_x (
        .aclk(aclk), .ce(ce),
        .a(term_word[WORD_W-1:COEF_LSB]), .b(sel_x),
        .sat_in(sat_x | sat_y | sat_z),
        .side_in({active, sel_z, sel_y}),
        .q(t0), .sat(s0), .side_out(side0)
    );

    // Times the y power.
    tpe_mul_sat #(
        .A_W(Q_W), .B_W(Q_W), .SHIFT(16), .SIDE_W(Q_W + 1)
    ) u_mul_y (
        .aclk(aclk), .ce(ce),
        .a(t0), .b(side0[Q_W-1:0]),
        .sat_in(s0),
        .side_in(side0[2*Q_W:Q_W]),
        .q(t1), .sat(s1), .side_out(side1)
    );

    // Times the z power.
    tpe_mul_sat #(
        .A_W(Q_W), .B_W(Q_W), .SHIFT(16), .SIDE_W(1)
    ) u_mul_z (
        .aclk(aclk), .ce(ce),
        .a(t1), .b(side1[Q_W-1:0]),
        .sat_in(s1),
        .side_in(side1[Q_W]),
        .q(term), .sat(term_sat), .side_out(term_active)
    );

endmodule

/* src/trivariate_polynomial_eval.sv */
// ----------------------------------------------------------------------------
// Trivariate polynomial evaluator
// Streams argument triples and returns the saturated sum of up to seven
// configured terms coef * x^a * y^b * z^c in Q32.16.
// ----------------------------------------------------------------------------
// One word is accepted every clock while the output is not stalled; each
// result passes through each argument's power chain, the three multiplies
// of a term lane, and the adder tree that ends in the output register. The
// whole pipeline shares one clock enable, so when m_tready is low with a
// result waiting, every stage holds and s_tready drops; bubbles in between
// are absorbed only at the output. The user must write configuration only
// while no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module trivariate_polynomial_eval #(
    parameter int MAX_TERMS  = tpe_pkg::DEF_MAX_TERMS,
    parameter int MAX_DEGREE = tpe_pkg::DEF_MAX_DEGREE
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpe_pkg::WORD_W-1:0]        cfg_data,
    // Argument stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [47:0]                       s_tdata,  // x_value, y_value, z_value
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,  // poly_value
    output logic                              m_tuser   // saturated
);
    import tpe_pkg::*;

    localparam int LAT   = 2 * MAX_DEGREE + 8;
    localparam int HALF  = (MAX_TERMS + 1) / 2;
    localparam int SUM_W = Q_W + 3;

    logic [CNT_W-1:0]   term_count_reg;
    logic [WORD_W-1:0]  term_word_reg [0:MAX_TERMS-1];
    logic [CNT_W-1:0]   n_act;

    logic               ce;
    logic [LAT-1:0]     valid_reg;

    logic [MAX_DEGREE:0][Q_W-1:0] pw_x, pw_y, pw_z;
    logic [MAX_DEGREE:0]          ps_x, ps_y, ps_z;

    q_t                 lane_term [0:MAX_TERMS-1];
    logic [MAX_TERMS-1:0] lane_sat;
    logic [MAX_TERMS-1:0] lane_act;

    logic signed [SUM_W-1:0] lo_next, hi_next;
    logic                    sat_s1_next;
    logic signed [SUM_W-1:0] lo_reg, hi_reg;
    logic                    sat_s1_reg;

    logic signed [SUM_W:0]   total;
    logic [SUM_W-Q_W+1:0]    total_top;
    logic                    sum_ovf;
    logic [Q_W-1:0]          poly_next;
    logic [Q_W-1:0]          poly_reg;
    logic                    sat_out_reg;

    // Configuration registers; any write is taken at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= '0;
            for (int i = 0; i < MAX_TERMS; i++) begin
                term_word_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TERM_COUNT: term_count_reg <= cfg_data[CNT_W-1:0];
                default: begin
                    for (int i = 0; i < MAX_TERMS; i++) begin
                        if (cfg_index == CFG_TERM_WORD_0 + CFG_IDX_W'(i)) begin
                            term_word_reg[i] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    assign n_act = (term_count_reg > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                        : term_count_reg;

    // Shared pipeline enable and the valid shift line.
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    // Power tables for the three arguments.
    tpe_power_chain #(.MAX_DEGREE(MAX_DEGREE)) u_pow_x (
        .aclk(aclk), .ce(ce), .arg(s_tdata[15:0]), .pw(pw_x), .ps(ps_x)
    );
    tpe_power_chain #(.MAX_DEGREE(MAX_DEGREE)) u_pow_y (
        .aclk(aclk), .ce(ce), .arg(s_tdata[31:16]), .pw(pw_y), .ps(ps_y)
    );
    tpe_power_chain #(.MAX_DEGREE(MAX_DEGREE)) u_pow_z (
        .aclk(aclk), .ce(ce), .arg(s_tdata[47:32]), .pw(pw_z), .ps(ps_z)
    );

    // One lane per term.
    genvar g;
    generate
        for (g = 0; g < MAX_TERMS; g++) begin : g_lane
            tpe_term_lane #(.MAX_DEGREE(MAX_DEGREE)) u_lane (
                .aclk(aclk), .ce(ce),
                .term_word(term_word_reg[g]),
                .active(CNT_W'(g) < n_act),
                .pw_x(pw_x), .pw_y(pw_y), .pw_z(pw_z),
                .ps_x(ps_x), .ps_y(ps_y), .ps_z(ps_z),
                .term(lane_term[g]), .term_sat(lane_sat[g]),
                .term_active(lane_act[g])
            );
        end
    endgenerate

    // First adder level: two partial sums over the active lanes.
    always_comb begin
        lo_next     = '0;
        hi_next     = '0;
        sat_s1_next = 1'b0;
        for (int i = 0; i < MAX_TERMS; i++) begin
            if (lane_act[i]) begin
                sat_s1_next = sat_s1_next | lane_sat[i];
                if (i < HALF) begin
                    lo_next = lo_next + SUM_W'(lane_term[i]);
                end else begin
                    hi_next = hi_next + SUM_W'(lane_term[i]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            sat_s1_reg <= sat_s1_next;
        end
    end

    // Final add and clamp into the output register.
    always_comb begin
        total     = (SUM_W + 1)'(lo_reg) + (SUM_W + 1)'(hi_reg);
        total_top = total[SUM_W:Q_W-1];
        sum_ovf   = !((&total_top) || !(|total_top));
        if (sum_ovf) begin
            poly_next = total[SUM_W] ? Q_MIN : Q_MAX;
        end else begin
            poly_next = total[Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            poly_reg    <= poly_next;
            sat_out_reg <= sat_s1_reg | sum_ovf;
        end
    end

    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = poly_reg;
    assign m_tuser  = sat_out_reg;

    // The pipeline comes out of reset empty.
    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> (valid_reg == '0))
        else $error("valid line not cleared by reset");

    // A stall freezes every valid bit.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(valid_reg))
        else $error("valid line moved during a stall");

    // With no terms in use the result is a clean zero.
    a_zero_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && term_count_reg == '0) |-> (m_tdata == '0 && !m_tuser))
        else $error("nonzero result with no terms in use");

endmodule
